// ===== hw/rtl/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_HEAD = 3'd0,
    ACT_PUSH_TAIL = 3'd1,
    ACT_POP_HEAD  = 3'd2,
    ACT_POP_TAIL  = 3'd3,
    ACT_READ_HEAD = 3'd4,
    ACT_READ_TAIL = 3'd5,
    ACT_READ_POS  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  function automatic logic [ADDR_W-1:0] wrap_index(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return ADDR_W'(sum);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bdq_ram.sv =====
`default_nettype none
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_deque_with_index_read.sv =====
// A result beat is valid in the cycle after its request beat is taken.
// Throughput: one request per cycle; the single-port element RAM does at most one
// read or one write per request, and a request is taken whenever the output
// register is empty or being drained in the same cycle.
// Reset clears the head pointer, the element count and the output valid;
// the element RAM is not cleared.
`default_nettype none
module bounded_deque_with_index_read (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] value,
  input  wire logic [7:0]  position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      data,
  output logic [1:0]       status,
  output logic [8:0]       count
);

  logic [bdq_pkg::ADDR_W-1:0]     head;
  logic [bdq_pkg::ADDR_W-1:0]     head_next;
  logic [bdq_pkg::CNT_W-1:0]      cnt;
  logic [bdq_pkg::CNT_W-1:0]      cnt_next;
  logic [bdq_pkg::ADDR_W-1:0]     addr;
  logic                           we_c;
  logic                           re_c;
  bdq_pkg::status_t               st_c;
  bdq_pkg::status_t               status_r;
  logic [bdq_pkg::CNT_W-1:0]      count_r;
  logic                           rd_r;
  logic [bdq_pkg::DATA_WIDTH-1:0] rd_data;
  logic                           accept;
  logic                           full;
  logic                           empty;
  logic                           pos_oor;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = cnt >= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY);
  assign empty    = cnt == '0;
  assign pos_oor  = 32'(position) >= 32'(cnt);

  always_comb begin
    head_next = head;
    cnt_next  = cnt;
    addr      = head;
    we_c      = 1'b0;
    re_c      = 1'b0;
    st_c      = bdq_pkg::ST_OK;
    unique case (bdq_pkg::action_t'(action))
      bdq_pkg::ACT_PUSH_HEAD, bdq_pkg::ACT_PUSH_TAIL: begin
        if (full) begin
          st_c = bdq_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + bdq_pkg::CNT_W'(1);
          we_c     = 1'b1;
          if (bdq_pkg::action_t'(action) == bdq_pkg::ACT_PUSH_HEAD) begin
            head_next = (head == '0) ? bdq_pkg::ADDR_W'(bdq_pkg::CAPACITY - 1)
                                     : head - bdq_pkg::ADDR_W'(1);
            addr      = head_next;
          end else begin
            addr = bdq_pkg::wrap_index(head, cnt);
          end
        end
      end
      bdq_pkg::ACT_POP_HEAD, bdq_pkg::ACT_POP_TAIL: begin
        if (empty) begin
          st_c = bdq_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - bdq_pkg::CNT_W'(1);
          if (bdq_pkg::action_t'(action) == bdq_pkg::ACT_POP_HEAD) begin
            head_next = bdq_pkg::wrap_index(head, bdq_pkg::CNT_W'(1));
          end
        end
      end
      bdq_pkg::ACT_READ_HEAD: begin
        if (empty) begin
          st_c = bdq_pkg::ST_EMPTY;
        end else begin
          re_c = 1'b1;
        end
      end
      bdq_pkg::ACT_READ_TAIL: begin
        if (empty) begin
          st_c = bdq_pkg::ST_EMPTY;
        end else begin
          re_c = 1'b1;
          addr = bdq_pkg::wrap_index(head, cnt - bdq_pkg::CNT_W'(1));
        end
      end
      bdq_pkg::ACT_READ_POS: begin
        if (pos_oor) begin
          st_c = bdq_pkg::ST_RANGE;
        end else begin
          re_c = 1'b1;
          addr = bdq_pkg::wrap_index(head, bdq_pkg::CNT_W'(position));
        end
      end
      default: begin
        st_c = bdq_pkg::ST_OK;
      end
    endcase
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_WIDTH),
    .DEPTH (bdq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (accept && we_c),
    .re    (accept && re_c),
    .addr  (addr),
    .wdata (value[bdq_pkg::DATA_WIDTH-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      head      <= head_next;
      cnt       <= cnt_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result beat payload until the next request is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= st_c;
      count_r  <= cnt_next;
      rd_r     <= re_c;
    end
  end

  assign data   = rd_r ? 32'(rd_data) : 32'd0;
  assign status = status_r;
  assign count  = 9'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY))
    else $error("element count above capacity");

  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && data != 32'd0 |-> status == bdq_pkg::ST_OK)
    else $error("data returned with error status");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && we_c |=> cnt == $past(cnt) + bdq_pkg::CNT_W'(1))
    else $error("push did not grow count");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && count_r == cnt)
    else $error("result count differs from held count");

endmodule
`default_nettype wire
